// ===== sv/cbc_pkg.sv =====
// Shared types and constants for the cyclic box copy address generator.
// No dependencies.
package cbc_pkg;

   localparam int LEN_W     = 11;
   localparam int ORI_W     = 10;
   localparam int EB_W      = 5;
   localparam int OFF_W     = 34;
   localparam int CSR_IDX_W = 3;
   localparam int ST_W      = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_LEN_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_LEN_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_LEN_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_LEN_X      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_LEN_Y      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_LEN_Z      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_ELEM_BYTES = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_ELEM_BYTES = 3'd7;

   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [ST_W-1:0] ST_NO_JOB = 2'd2;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_NEXT  = 1'b1;

   typedef struct packed {
      logic [2:0][LEN_W-1:0] src_len;
      logic [2:0][LEN_W-1:0] dst_len;
      logic [EB_W-1:0]       src_bytes;
      logic [EB_W-1:0]       dst_bytes;
   } cfg_type;

   typedef struct packed {
      logic                  action;
      logic                  box_empty;
      logic [2:0][ORI_W-1:0] origin;
      logic [2:0][LEN_W-1:0] blen;
      logic [2:0][ORI_W-1:0] pos;
   } cmd_type;

endpackage

// ===== sv/cyclic_box_copy_address_gen.sv =====
// Top level of the cyclic box copy address generator: config registers,
// front end, command queue and run sequencer. Depends on cbc_pkg and submodules.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | action, box origin, length, pos
//   rsp     | out       | rsp_valid / rsp_stall | offsets, run_count, last, status
//   csr     | in        | csr_write_enable      | csr_index, csr_data
//
// A start request runs an iterative modulo in the sequencer: one modulo
// bit per cycle for source and destination, one dimension after the other.
// A next request steps through normalize, two multiply stages, add, scale, emit.
// Reset is synchronous and clears control state; config resets to 1.
// A two-entry queue lets requests enter while the sequencer or rsp is stalled.
module cyclic_box_copy_address_gen import cbc_pkg::*; #(
   parameter int NUM_DIMS = 3,
   parameter int MAX_LEN  = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [ORI_W-1:0]     req_box_origin_x,
   input  logic [ORI_W-1:0]     req_box_origin_y,
   input  logic [ORI_W-1:0]     req_box_origin_z,
   input  logic [LEN_W-1:0]     req_box_len_x,
   input  logic [LEN_W-1:0]     req_box_len_y,
   input  logic [LEN_W-1:0]     req_box_len_z,
   input  logic [ORI_W-1:0]     req_box_pos_x,
   input  logic [ORI_W-1:0]     req_box_pos_y,
   input  logic [ORI_W-1:0]     req_box_pos_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OFF_W-1:0]     rsp_src_offset,
   output logic [OFF_W-1:0]     rsp_dst_offset,
   output logic [LEN_W-1:0]     rsp_run_count,
   output logic                 rsp_last,
   output logic [ST_W-1:0]      rsp_status,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_data
);

   logic [LEN_W-1:0] src_len_ff [3], dst_len_ff [3];
   logic [EB_W-1:0]  src_bytes_ff, dst_bytes_ff;
   cfg_type          cfg;
   cmd_type          req_cmd, push_cmd, pop_cmd;
   logic             push_valid, push_ready, pop_valid, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < 3; d++) begin
            src_len_ff[d] <= LEN_W'(1);
            dst_len_ff[d] <= LEN_W'(1);
         end
         src_bytes_ff <= EB_W'(1);
         dst_bytes_ff <= EB_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SRC_LEN_X:      src_len_ff[0] <= csr_data;
            CSR_SRC_LEN_Y:      src_len_ff[1] <= csr_data;
            CSR_SRC_LEN_Z:      src_len_ff[2] <= csr_data;
            CSR_DST_LEN_X:      dst_len_ff[0] <= csr_data;
            CSR_DST_LEN_Y:      dst_len_ff[1] <= csr_data;
            CSR_DST_LEN_Z:      dst_len_ff[2] <= csr_data;
            CSR_SRC_ELEM_BYTES: src_bytes_ff <= csr_data[EB_W-1:0];
            CSR_DST_ELEM_BYTES: dst_bytes_ff <= csr_data[EB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // lengths saturate at MAX_LEN
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         cfg.src_len[d] = (32'(src_len_ff[d]) > MAX_LEN) ? LEN_W'(MAX_LEN) : src_len_ff[d];
         cfg.dst_len[d] = (32'(dst_len_ff[d]) > MAX_LEN) ? LEN_W'(MAX_LEN) : dst_len_ff[d];
      end
      cfg.src_bytes = src_bytes_ff;
      cfg.dst_bytes = dst_bytes_ff;
   end

   always_comb begin
      req_cmd.action    = req_action;
      req_cmd.box_empty = 1'b0;
      req_cmd.origin[0] = req_box_origin_x;
      req_cmd.origin[1] = req_box_origin_y;
      req_cmd.origin[2] = req_box_origin_z;
      req_cmd.blen[0]   = req_box_len_x;
      req_cmd.blen[1]   = req_box_len_y;
      req_cmd.blen[2]   = req_box_len_z;
      req_cmd.pos[0]    = req_box_pos_x;
      req_cmd.pos[1]    = req_box_pos_y;
      req_cmd.pos[2]    = req_box_pos_z;
   end

   cbc_front #(.NUM_DIMS(NUM_DIMS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   cbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   cbc_back #(.NUM_DIMS(NUM_DIMS), .MAX_LEN(MAX_LEN)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (pop_valid),
      .q_cmd          (pop_cmd),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_src_offset (rsp_src_offset),
      .rsp_dst_offset (rsp_dst_offset),
      .rsp_run_count  (rsp_run_count),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== sv/cbc_front.sv =====
// Request front end: accepts requests, clamps box lengths, flags empty boxes.
// Depends on cbc_pkg.
module cbc_front import cbc_pkg::*; #(
   parameter int NUM_DIMS = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  cmd_type req_cmd,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;

   always_comb begin
      cmd_in = req_cmd;
      cmd_in.box_empty = 1'b0;
      for (int d = 0; d < 3; d++) begin
         if (req_cmd.blen[d] > cfg.dst_len[d]) begin
            cmd_in.blen[d] = cfg.dst_len[d];
         end
         if (d < NUM_DIMS && cmd_in.blen[d] == '0) begin
            cmd_in.box_empty = 1'b1;
         end
      end
   end

   assign req_stall  = valid_ff && !push_ready;
   assign valid_in   = (req_valid && !req_stall) || (valid_ff && !push_ready);
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && !req_stall) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== sv/cbc_queue.sv =====
// Two-entry command queue between front end and run sequencer.
// Depends on cbc_pkg.
module cbc_queue import cbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop,
   output cmd_type pop_cmd
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(pop);
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/cbc_back.sv =====
// Run sequencer: loads boxes (iterative modulo), walks runs, computes offsets.
// Depends on cbc_pkg.
module cbc_back import cbc_pkg::*; #(
   parameter int NUM_DIMS = 3,
   parameter int MAX_LEN  = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             q_valid,
   input  cmd_type          q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [OFF_W-1:0] rsp_src_offset,
   output logic [OFF_W-1:0] rsp_dst_offset,
   output logic [LEN_W-1:0] rsp_run_count,
   output logic             rsp_last,
   output logic [ST_W-1:0]  rsp_status
);

   localparam int IDX_W = (MAX_LEN > 2048) ? LEN_W : $clog2(MAX_LEN);
   localparam int BIT_W = $clog2(ORI_W);

   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_NORM, S_MUL1, S_MUL2, S_SUM, S_SCALE, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic job_ff, job_in;
   logic [IDX_W-1:0] si_ff [3], si_in [3], di_ff [3], di_in [3];
   logic [IDX_W-1:0] ssi_ff [3], ssi_in [3], sdi_ff [3], sdi_in [3];
   logic [LEN_W-1:0] rows_ff [3], rows_in [3], blen_ff [3], blen_in [3];
   logic [1:0] dim_ff, dim_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic [LEN_W-1:0] srem_ff, srem_in, drem_ff, drem_in;
   cmd_type cmd_ff, cmd_in;
   logic [2*LEN_W-1:0] ps_ff, ps_in, pd_ff, pd_in;
   logic [IDX_W+LEN_W-1:0] t1s_ff, t1s_in, t1d_ff, t1d_in;
   logic [IDX_W+2*LEN_W-1:0] t2s_ff, t2s_in, t2d_ff, t2d_in;
   logic [OFF_W-1:0] sums_ff, sums_in, sumd_ff, sumd_in;
   logic [OFF_W-1:0] offs_ff, offs_in, offd_ff, offd_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [OFF_W-1:0] rsp_so_ff, rsp_so_in, rsp_do_ff, rsp_do_in;
   logic [LEN_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [ST_W-1:0] rsp_st_ff, rsp_st_in;
   logic cfg_empty, out_free;

   always_comb begin
      cfg_empty = 1'b0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (cfg.src_len[d] == '0 || cfg.dst_len[d] == '0) begin
            cfg_empty = 1'b1;
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      logic [LEN_W:0]   shs, shd, sadd, dadd;
      logic [LEN_W-1:0] cnt, lim, r1, r2, inc;
      logic             done;
      state_in = state_ff; job_in = job_ff;
      for (int d = 0; d < 3; d++) begin
         si_in[d] = si_ff[d]; di_in[d] = di_ff[d];
         ssi_in[d] = ssi_ff[d]; sdi_in[d] = sdi_ff[d];
         rows_in[d] = rows_ff[d]; blen_in[d] = blen_ff[d];
      end
      dim_in = dim_ff; bit_in = bit_ff; srem_in = srem_ff; drem_in = drem_ff;
      cmd_in = cmd_ff;
      ps_in = ps_ff; pd_in = pd_ff; t1s_in = t1s_ff; t1d_in = t1d_ff;
      t2s_in = t2s_ff; t2d_in = t2d_ff; sums_in = sums_ff; sumd_in = sumd_ff;
      offs_in = offs_ff; offd_in = offd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_so_in = rsp_so_ff; rsp_do_in = rsp_do_ff; rsp_cnt_in = rsp_cnt_ff;
      rsp_last_in = rsp_last_ff; rsp_st_in = rsp_st_ff;
      q_pop = 1'b0;
      shs = '0; shd = '0; sadd = '0; dadd = '0;
      cnt = '0; lim = '0; r1 = '0; r2 = '0; inc = '0; done = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               rsp_so_in = '0; rsp_do_in = '0; rsp_cnt_in = '0; rsp_last_in = 1'b0;
               if (q_cmd.action == ACT_START) begin
                  job_in = 1'b0;
                  for (int d = 0; d < 3; d++) begin
                     si_in[d] = '0; di_in[d] = '0; ssi_in[d] = '0; sdi_in[d] = '0;
                     rows_in[d] = '0; blen_in[d] = '0;
                  end
                  if (cfg_empty || q_cmd.box_empty) begin
                     rsp_valid_in = 1'b1; rsp_st_in = ST_EMPTY;
                  end else begin
                     for (int d = 0; d < NUM_DIMS; d++) begin
                        blen_in[d] = q_cmd.blen[d];
                        rows_in[d] = q_cmd.blen[d];
                     end
                     cmd_in = q_cmd;
                     dim_in = '0; bit_in = BIT_W'(ORI_W - 1);
                     srem_in = '0; drem_in = '0;
                     state_in = S_MOD;
                  end
               end else if (!job_ff) begin
                  rsp_valid_in = 1'b1; rsp_st_in = ST_NO_JOB;
               end else if (cfg_empty) begin
                  job_in = 1'b0;
                  rsp_valid_in = 1'b1; rsp_st_in = ST_EMPTY;
               end else begin
                  q_pop = 1'b1;
                  state_in = S_NORM;
               end
            end
         end
         S_MOD: begin
            shs = {srem_ff, cmd_ff.origin[dim_ff][bit_ff]};
            shd = {drem_ff, cmd_ff.pos[dim_ff][bit_ff]};
            srem_in = (shs >= {1'b0, cfg.src_len[dim_ff]}) ?
                      LEN_W'(shs - {1'b0, cfg.src_len[dim_ff]}) : LEN_W'(shs);
            drem_in = (shd >= {1'b0, cfg.dst_len[dim_ff]}) ?
                      LEN_W'(shd - {1'b0, cfg.dst_len[dim_ff]}) : LEN_W'(shd);
            if (bit_ff == '0) begin
               si_in[dim_ff] = IDX_W'(srem_in); ssi_in[dim_ff] = IDX_W'(srem_in);
               di_in[dim_ff] = IDX_W'(drem_in); sdi_in[dim_ff] = IDX_W'(drem_in);
               srem_in = '0; drem_in = '0;
               bit_in = BIT_W'(ORI_W - 1);
               if (dim_ff == 2'(NUM_DIMS - 1)) begin
                  job_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  dim_in = dim_ff + 2'd1;
               end
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         S_NORM: begin
            for (int d = 0; d < NUM_DIMS; d++) begin
               if (LEN_W'(si_ff[d]) >= cfg.src_len[d]) si_in[d] = '0;
               if (LEN_W'(di_ff[d]) >= cfg.dst_len[d]) di_in[d] = '0;
            end
            state_in = S_MUL1;
         end
         S_MUL1: begin
            ps_in  = cfg.src_len[0] * cfg.src_len[1];
            pd_in  = cfg.dst_len[0] * cfg.dst_len[1];
            t1s_in = si_ff[1] * cfg.src_len[0];
            t1d_in = di_ff[1] * cfg.dst_len[0];
            state_in = S_MUL2;
         end
         S_MUL2: begin
            t2s_in = si_ff[2] * ps_ff;
            t2d_in = di_ff[2] * pd_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            sums_in = OFF_W'(t1s_ff) + OFF_W'(t2s_ff) + OFF_W'(si_ff[0]);
            sumd_in = OFF_W'(t1d_ff) + OFF_W'(t2d_ff) + OFF_W'(di_ff[0]);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            offs_in = OFF_W'(sums_ff * cfg.src_bytes);
            offd_in = OFF_W'(sumd_ff * cfg.dst_bytes);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cnt = cfg.src_len[0] - LEN_W'(si_ff[0]);
               if (cnt > rows_ff[0]) cnt = rows_ff[0];
               lim = cfg.dst_len[0] - LEN_W'(di_ff[0]);
               if (cnt > lim) cnt = lim;
               sadd = {1'b0, LEN_W'(si_ff[0])} + {1'b0, cnt};
               dadd = {1'b0, LEN_W'(di_ff[0])} + {1'b0, cnt};
               si_in[0] = (sadd >= {1'b0, cfg.src_len[0]}) ? '0 : IDX_W'(sadd);
               di_in[0] = (dadd >= {1'b0, cfg.dst_len[0]}) ? '0 : IDX_W'(dadd);
               rows_in[0] = rows_ff[0] - cnt;
               if (rows_in[0] == '0) begin
                  done = 1'b1;
                  if (NUM_DIMS > 1) begin
                     r1 = (rows_ff[1] != '0) ? rows_ff[1] - 1'b1 : '0;
                     rows_in[1] = r1;
                     inc = LEN_W'(si_ff[1]) + 1'b1;
                     si_in[1] = (inc >= cfg.src_len[1]) ? '0 : IDX_W'(inc);
                     inc = LEN_W'(di_ff[1]) + 1'b1;
                     di_in[1] = (inc >= cfg.dst_len[1]) ? '0 : IDX_W'(inc);
                     if (r1 != '0) begin
                        rows_in[0] = blen_ff[0];
                        si_in[0] = ssi_ff[0]; di_in[0] = sdi_ff[0];
                        done = 1'b0;
                     end else if (NUM_DIMS > 2) begin
                        r2 = (rows_ff[2] != '0) ? rows_ff[2] - 1'b1 : '0;
                        rows_in[2] = r2;
                        inc = LEN_W'(si_ff[2]) + 1'b1;
                        si_in[2] = (inc >= cfg.src_len[2]) ? '0 : IDX_W'(inc);
                        inc = LEN_W'(di_ff[2]) + 1'b1;
                        di_in[2] = (inc >= cfg.dst_len[2]) ? '0 : IDX_W'(inc);
                        if (r2 != '0) begin
                           for (int k = 0; k < 2; k++) begin
                              rows_in[k] = blen_ff[k];
                              si_in[k] = ssi_ff[k]; di_in[k] = sdi_ff[k];
                           end
                           done = 1'b0;
                        end
                     end
                  end
               end
               if (done) job_in = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_so_in = offs_ff; rsp_do_in = offd_ff; rsp_cnt_in = cnt;
               rsp_last_in = done; rsp_st_in = ST_OK;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < 3; d++) begin
            si_ff[d] <= '0; di_ff[d] <= '0; ssi_ff[d] <= '0; sdi_ff[d] <= '0;
            rows_ff[d] <= '0; blen_ff[d] <= '0;
         end
         dim_ff <= '0;
         bit_ff <= '0;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int d = 0; d < 3; d++) begin
            si_ff[d] <= si_in[d]; di_ff[d] <= di_in[d];
            ssi_ff[d] <= ssi_in[d]; sdi_ff[d] <= sdi_in[d];
            rows_ff[d] <= rows_in[d]; blen_ff[d] <= blen_in[d];
         end
         dim_ff <= dim_in;
         bit_ff <= bit_in;
      end
      srem_ff <= srem_in; drem_ff <= drem_in; cmd_ff <= cmd_in;
      ps_ff <= ps_in; pd_ff <= pd_in; t1s_ff <= t1s_in; t1d_ff <= t1d_in;
      t2s_ff <= t2s_in; t2d_ff <= t2d_in; sums_ff <= sums_in; sumd_ff <= sumd_in;
      offs_ff <= offs_in; offd_ff <= offd_in;
      rsp_so_ff <= rsp_so_in; rsp_do_ff <= rsp_do_in; rsp_cnt_ff <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in; rsp_st_ff <= rsp_st_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_src_offset = rsp_so_ff;
   assign rsp_dst_offset = rsp_do_ff;
   assign rsp_run_count  = rsp_cnt_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_st_ff;

`ifndef NO_ASSERTIONS
   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_st_ff != ST_OK |->
         rsp_so_ff == '0 && rsp_do_ff == '0 && rsp_cnt_ff == '0 && !rsp_last_ff)
      else $error("error response carries nonzero fields");
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_st_ff == ST_OK |-> rsp_cnt_ff != '0)
      else $error("valid run with zero count");
   a_no_job_while_loading: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOD |-> !job_ff)
      else $error("job active during box load");
`endif

endmodule
